>>> design/pfd_pkg.sv
// Shared constants, types and square-geometry functions for the Playfair decipher engine.
package pfd_pkg;

  localparam int unsigned SquareSide = 5;
  localparam int unsigned Cells      = SquareSide * SquareSide;
  localparam int unsigned NumLetters = 26;
  localparam int unsigned PosW       = $clog2(Cells);
  localparam int unsigned RowW       = $clog2(SquareSide);
  localparam int unsigned IdxW       = $clog2(NumLetters);

  localparam logic [IdxW-1:0] IdxJ       = IdxW'(9);
  localparam logic [IdxW-1:0] IdxX       = IdxW'(23);
  localparam logic [IdxW-1:0] IdxLast    = IdxW'(NumLetters - 1);
  localparam logic [PosW-1:0] CellsFull  = PosW'(Cells);
  localparam logic [6:0]      AsciiUpperA = 7'h41;
  localparam logic [7:0]      ByteUpperA  = 8'h41;
  localparam logic [7:0]      ByteUpperZ  = 8'h5A;
  localparam logic [7:0]      ByteLowerA  = 8'h61;
  localparam logic [7:0]      ByteLowerZ  = 8'h7A;
  localparam logic [7:0]      CaseOffset  = 8'h20;

  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_KEY     = 2'd1,
    CMD_END_KEY = 2'd2,
    CMD_CIPHER  = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_FILL,
    ST_LPA,
    ST_LPB,
    ST_TGT,
    ST_SQ1,
    ST_SQ2,
    ST_RES1,
    ST_RES2
  } state_e;

  // Status from datapath to controller
  typedef struct packed {
    cmd_e       cmd;
    logic [1:0] num_pairs;
    logic       walk_done;
    logic       slot_free;
  } pfd_sts_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;
    logic dispatch;
    logic walk_step;
    logic lp_rd_a;
    logic lp_rd_b;
    logic tgt;
    logic sq_rd1;
    logic sq_rd2;
    logic load_res1;
    logic load_res2;
    logic res_last;
    logic load_pair2;
  } pfd_cmd_t;

  // Row of a place in the square
  function automatic logic [RowW-1:0] pos_row(logic [PosW-1:0] pos);
    logic [RowW-1:0] row;
    row = '0;
    for (int r = 1; r < SquareSide; r++) begin
      if (pos >= PosW'(r * SquareSide)) row = RowW'(r);
    end
    return row;
  endfunction

  // Column of a place in the square
  function automatic logic [RowW-1:0] pos_col(logic [PosW-1:0] pos);
    logic [PosW-1:0] base;
    logic [PosW-1:0] diff;
    base = PosW'(PosW'(pos_row(pos)) * PosW'(SquareSide));
    diff = pos - base;
    return diff[RowW-1:0];
  endfunction

  // Place from row and column
  function automatic logic [PosW-1:0] rc_pos(logic [RowW-1:0] row, logic [RowW-1:0] col);
    return PosW'(PosW'(row) * PosW'(SquareSide) + PosW'(col));
  endfunction

  // Step one row or column back, with wrap
  function automatic logic [RowW-1:0] wrap_dec(logic [RowW-1:0] v);
    return (v == '0) ? RowW'(SquareSide - 1) : RowW'(v - 1'b1);
  endfunction

endpackage

>>> design/pfd_in_if.sv
// Input channel: command, letter and message-end marker with valid/ready.
interface pfd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] letter;
  logic       final_letter;

  modport source (output valid, command, letter, final_letter, input ready);
  modport sink   (input valid, command, letter, final_letter, output ready);
endinterface

>>> design/pfd_out_if.sv
// Output channel: plaintext letter results with valid/ready.
interface pfd_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] plain_letter;
  logic       not_in_square;
  logic       last_of_run;

  modport source (output valid, plain_letter, not_in_square, last_of_run, input ready);
  modport sink   (input valid, plain_letter, not_in_square, last_of_run, output ready);
endinterface

>>> design/pfd_ctrl.sv
// Controller state machine sequencing key fill and digraph decoding.
module pfd_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  pfd_pkg::pfd_sts_t sts_i,
  output pfd_pkg::pfd_cmd_t cmd_o
);

  pfd_pkg::state_e state_q, state_d;
  logic two_q, two_d;
  logic second_q, second_d;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pfd_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = pfd_pkg::ST_DISPATCH;
      end
      pfd_pkg::ST_DISPATCH: begin
        case (sts_i.cmd)
          pfd_pkg::CMD_END_KEY: state_d = pfd_pkg::ST_FILL;
          pfd_pkg::CMD_CIPHER: begin
            state_d = (sts_i.num_pairs != 2'd0) ? pfd_pkg::ST_LPA : pfd_pkg::ST_IDLE;
          end
          default: state_d = pfd_pkg::ST_IDLE;
        endcase
      end
      pfd_pkg::ST_FILL: begin
        if (sts_i.walk_done) state_d = pfd_pkg::ST_IDLE;
      end
      pfd_pkg::ST_LPA: state_d = pfd_pkg::ST_LPB;
      pfd_pkg::ST_LPB: state_d = pfd_pkg::ST_TGT;
      pfd_pkg::ST_TGT: state_d = pfd_pkg::ST_SQ1;
      pfd_pkg::ST_SQ1: state_d = pfd_pkg::ST_SQ2;
      pfd_pkg::ST_SQ2: state_d = pfd_pkg::ST_RES1;
      pfd_pkg::ST_RES1: begin
        if (sts_i.slot_free) state_d = pfd_pkg::ST_RES2;
      end
      pfd_pkg::ST_RES2: begin
        if (sts_i.slot_free) begin
          state_d = (two_q && !second_q) ? pfd_pkg::ST_LPA : pfd_pkg::ST_IDLE;
        end
      end
      default: state_d = pfd_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    two_d      = two_q;
    second_d   = second_q;
    case (state_q)
      pfd_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      pfd_pkg::ST_DISPATCH: begin
        cmd_o.dispatch = 1'b1;
        two_d          = (sts_i.num_pairs == 2'd2);
        second_d       = 1'b0;
      end
      pfd_pkg::ST_FILL: cmd_o.walk_step = 1'b1;
      pfd_pkg::ST_LPA:  cmd_o.lp_rd_a   = 1'b1;
      pfd_pkg::ST_LPB:  cmd_o.lp_rd_b   = 1'b1;
      pfd_pkg::ST_TGT:  cmd_o.tgt       = 1'b1;
      pfd_pkg::ST_SQ1:  cmd_o.sq_rd1    = 1'b1;
      pfd_pkg::ST_SQ2:  cmd_o.sq_rd2    = 1'b1;
      pfd_pkg::ST_RES1: cmd_o.load_res1 = sts_i.slot_free;
      pfd_pkg::ST_RES2: begin
        cmd_o.load_res2  = sts_i.slot_free;
        cmd_o.res_last   = !two_q || second_q;
        cmd_o.load_pair2 = sts_i.slot_free && two_q && !second_q;
        if (cmd_o.load_pair2) second_d = 1'b1;
      end
      default: cmd_o = '0;
    endcase
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= pfd_pkg::ST_IDLE;
      two_q    <= 1'b0;
      second_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      two_q    <= two_d;
      second_q <= second_d;
    end
  end

endmodule

>>> design/pfd_dp.sv
// Datapath: key square tables, pending letter, digraph geometry and result register.
module pfd_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [1:0]        command_i,
  input  logic [7:0]        letter_i,
  input  logic              final_letter_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [6:0]        plain_letter_o,
  output logic              not_in_square_o,
  output logic              last_of_run_o,
  input  pfd_pkg::pfd_cmd_t cmd_i,
  output pfd_pkg::pfd_sts_t sts_o
);

  localparam int unsigned PosW = pfd_pkg::PosW;
  localparam int unsigned RowW = pfd_pkg::RowW;
  localparam int unsigned IdxW = pfd_pkg::IdxW;

  // Tables: letters by place, places by letter
  logic [IdxW-1:0] sq_mem [pfd_pkg::Cells];
  logic [PosW-1:0] lp_mem [pfd_pkg::NumLetters];
  logic [IdxW-1:0] sq_rdata_q;
  logic [PosW-1:0] lp_rdata_q;

  // Latched input transaction
  pfd_pkg::cmd_e   cmd_q;
  logic            lv_q;
  logic [IdxW-1:0] li_q;
  logic            fin_q;

  // Square state
  logic [pfd_pkg::NumLetters-1:0] seen_q;
  logic [PosW-1:0]                fill_q;
  logic [IdxW-1:0]                pend_q;
  logic                           pv_q;
  logic [IdxW-1:0]                walk_q;

  // Pair decode registers
  logic [IdxW-1:0] op_a_q, op_b_q;
  logic [PosW-1:0] pos_a_q;
  logic [PosW-1:0] t1_q, t2_q;
  logic            e1_q, e2_q;
  logic [IdxW-1:0] l1_q;

  // Result register
  logic       out_valid_q;
  logic [6:0] plain_q;
  logic       nis_q;
  logic       last_q;

  // Fold input byte to a letter index
  logic [7:0]      up_byte;
  logic            in_lv;
  logic [7:0]      in_off;
  always_comb begin
    up_byte = letter_i;
    if (letter_i >= pfd_pkg::ByteLowerA && letter_i <= pfd_pkg::ByteLowerZ) begin
      up_byte = letter_i - pfd_pkg::CaseOffset;
    end
    in_lv  = (up_byte >= pfd_pkg::ByteUpperA) && (up_byte <= pfd_pkg::ByteUpperZ);
    in_off = up_byte - pfd_pkg::ByteUpperA;
  end

  // Latch the accepted transaction
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cmd_q <= pfd_pkg::cmd_e'(command_i);
      lv_q  <= in_lv;
      li_q  <= in_off[IdxW-1:0];
      fin_q <= final_letter_i;
    end
  end

  // Pair plan for a cipher letter
  logic [1:0]      np;
  logic [IdxW-1:0] a1, b1;
  logic            pv_nx;
  logic [IdxW-1:0] pend_nx;
  always_comb begin
    np      = 2'd0;
    a1      = pend_q;
    b1      = pfd_pkg::IdxX;
    pv_nx   = pv_q;
    pend_nx = pend_q;
    if (!lv_q) begin
      if (fin_q && pv_q) begin
        np    = 2'd1;
        pv_nx = 1'b0;
      end
    end else if (!pv_q) begin
      if (fin_q) begin
        np = 2'd1;
        a1 = li_q;
      end else begin
        pend_nx = li_q;
        pv_nx   = 1'b1;
      end
    end else if (pend_q == li_q) begin
      np = fin_q ? 2'd2 : 2'd1;
      if (fin_q) pv_nx = 1'b0;
    end else begin
      np    = 2'd1;
      b1    = li_q;
      pv_nx = 1'b0;
    end
  end

  // Append one letter to the square
  logic            app_req;
  logic [IdxW-1:0] app_idx;
  logic            app_en;
  always_comb begin
    app_req = cmd_i.walk_step ||
              (cmd_i.dispatch && cmd_q == pfd_pkg::CMD_KEY && lv_q);
    app_idx = cmd_i.walk_step ? walk_q : li_q;
    app_en  = app_req && (app_idx != pfd_pkg::IdxJ) && !seen_q[app_idx] &&
              (fill_q < pfd_pkg::CellsFull);
  end

  // Square control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
      fill_q <= '0;
      pend_q <= '0;
      pv_q   <= 1'b0;
    end else if (cmd_i.dispatch && cmd_q == pfd_pkg::CMD_CLEAR) begin
      seen_q <= '0;
      fill_q <= '0;
      pend_q <= '0;
      pv_q   <= 1'b0;
    end else begin
      if (app_en) begin
        seen_q[app_idx] <= 1'b1;
        fill_q          <= fill_q + 1'b1;
      end
      if (cmd_i.dispatch && cmd_q == pfd_pkg::CMD_CIPHER) begin
        pend_q <= pend_nx;
        pv_q   <= pv_nx;
      end
    end
  end

  // Walk over the alphabet for end of key
  always_ff @(posedge clk_i) begin
    if (cmd_i.dispatch) walk_q <= '0;
    else if (cmd_i.walk_step) walk_q <= walk_q + 1'b1;
  end

  // Table writes
  always_ff @(posedge clk_i) begin
    if (app_en) begin
      sq_mem[fill_q]  <= app_idx;
      lp_mem[app_idx] <= fill_q;
    end
  end

  // Table reads, registered
  always_ff @(posedge clk_i) begin
    if (cmd_i.lp_rd_a || cmd_i.lp_rd_b) begin
      lp_rdata_q <= lp_mem[cmd_i.lp_rd_a ? op_a_q : op_b_q];
    end
    if (cmd_i.sq_rd1 || cmd_i.sq_rd2) begin
      sq_rdata_q <= sq_mem[cmd_i.sq_rd1 ? t1_q : t2_q];
    end
  end

  // Pair operands
  always_ff @(posedge clk_i) begin
    if (cmd_i.dispatch) begin
      op_a_q <= a1;
      op_b_q <= b1;
    end else if (cmd_i.load_pair2) begin
      op_a_q <= li_q;
      op_b_q <= pfd_pkg::IdxX;
    end
  end

  // Target places of the two plaintext letters
  logic            perr;
  logic [PosW-1:0] pa, pb, t1, t2;
  logic [RowW-1:0] ra, ca, rb, cb;
  always_comb begin
    perr = !seen_q[op_a_q] || !seen_q[op_b_q];
    pa   = perr ? '0 : pos_a_q;
    pb   = perr ? '0 : lp_rdata_q;
    ra   = pfd_pkg::pos_row(pa);
    ca   = pfd_pkg::pos_col(pa);
    rb   = pfd_pkg::pos_row(pb);
    cb   = pfd_pkg::pos_col(pb);
    if (ra == rb) begin
      t1 = pfd_pkg::rc_pos(ra, pfd_pkg::wrap_dec(ca));
      t2 = pfd_pkg::rc_pos(rb, pfd_pkg::wrap_dec(cb));
    end else if (ca == cb) begin
      t1 = pfd_pkg::rc_pos(pfd_pkg::wrap_dec(ra), ca);
      t2 = pfd_pkg::rc_pos(pfd_pkg::wrap_dec(rb), cb);
    end else begin
      t1 = pfd_pkg::rc_pos(ra, cb);
      t2 = pfd_pkg::rc_pos(rb, ca);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lp_rd_b) pos_a_q <= lp_rdata_q;
    if (cmd_i.tgt) begin
      t1_q <= t1;
      t2_q <= t2;
      e1_q <= perr || (t1 >= fill_q);
      e2_q <= perr || (t2 >= fill_q);
    end
    if (cmd_i.sq_rd2) l1_q <= sq_rdata_q;
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_res1 || cmd_i.load_res2) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_res1) begin
      plain_q <= e1_q ? '0 : pfd_pkg::AsciiUpperA + 7'(l1_q);
      nis_q   <= e1_q;
      last_q  <= 1'b0;
    end else if (cmd_i.load_res2) begin
      plain_q <= e2_q ? '0 : pfd_pkg::AsciiUpperA + 7'(sq_rdata_q);
      nis_q   <= e2_q;
      last_q  <= cmd_i.res_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign plain_letter_o  = plain_q;
  assign not_in_square_o = nis_q;
  assign last_of_run_o   = last_q;

  always_comb begin
    sts_o           = '0;
    sts_o.cmd       = cmd_q;
    sts_o.num_pairs = np;
    sts_o.walk_done = (walk_q == pfd_pkg::IdxLast);
    sts_o.slot_free = !out_valid_q || out_ready_i;
  end

endmodule

>>> design/playfair_decipher.sv
// Top level of the Playfair decipher engine: controller, datapath and channel ports.
//
//   channel   | dir | payload                                      | handshake
//   cipher_i  | in  | command, letter, final_letter                 | valid/ready
//   plain_o   | out | plain_letter, not_in_square, last_of_run      | valid/ready
//
// Clear, key letter and a cipher letter that only waits for its partner end after
// dispatch. End of key walks the alphabet, one step per letter. A digraph reads two
// places, forms targets, reads two letters and loads two results via the single read
// port of each key table. Reset empties the square; unwritten table reads are masked.
// A stalled result holds in the output register; the sequencer waits on it.
module playfair_decipher (
  input logic     clk_i,
  input logic     rst_ni,
  pfd_in_if.sink  cipher_i,
  pfd_out_if.source plain_o
);

  pfd_pkg::pfd_sts_t sts;
  pfd_pkg::pfd_cmd_t cmd;

  pfd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (cipher_i.valid),
    .in_ready_o (cipher_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pfd_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .command_i       (cipher_i.command),
    .letter_i        (cipher_i.letter),
    .final_letter_i  (cipher_i.final_letter),
    .out_ready_i     (plain_o.ready),
    .out_valid_o     (plain_o.valid),
    .plain_letter_o  (plain_o.plain_letter),
    .not_in_square_o (plain_o.not_in_square),
    .last_of_run_o   (plain_o.last_of_run),
    .cmd_i           (cmd),
    .sts_o           (sts)
  );

  // A result is loaded only into a free output slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.load_res1 || cmd.load_res2) |-> sts.slot_free)
    else $error("result loaded over an untaken result");

  // No second transaction is taken right after one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cipher_i.valid && cipher_i.ready) |=> !cipher_i.ready)
    else $error("input taken while busy");

  // At most one sequencer step per cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.accept, cmd.dispatch, cmd.walk_step, cmd.lp_rd_a, cmd.lp_rd_b,
              cmd.tgt, cmd.sq_rd1, cmd.sq_rd2, cmd.load_res1, cmd.load_res2}))
    else $error("overlapping sequencer steps");

  // The second pair is set up only together with the first pair's last result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_pair2 |-> (cmd.load_res2 && !cmd.res_last))
    else $error("second digraph started out of turn");

endmodule

>>> tb/pfd_checker.sv
// Playfair decipher checker: tracks the key square, predicts plaintext and compares results.
`timescale 1ns / 1ps

module pfd_checker
  import pfd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  pfd_in_if         cipher_i,
  pfd_out_if        plain_i,
  output int        error_count_o,
  output int        pending_count_o
);

  typedef struct packed {
    logic [6:0] plain_letter;
    logic       not_in_square;
    logic       last_of_run;
  } plain_res_t;

  plain_res_t      plain_q[$];

  // Shadow copy of the key square
  logic [IdxW-1:0] square_tab[Cells];
  logic [PosW-1:0] place_tab[NumLetters];
  logic [NumLetters-1:0] seen = '0;
  int unsigned     fill = 0;
  int unsigned     held_letter = 0;
  logic            held_valid = 1'b0;

  int              errors = 0;
  int              waiting = 0;

  assign error_count_o   = errors;
  assign pending_count_o = waiting;

  // Map an ASCII byte to a letter index, -1 for anything that is not a letter
  function automatic int letter_index(logic [7:0] b);
    logic [7:0] u;
    u = b;
    if (u >= ByteLowerA && u <= ByteLowerZ) u = u - CaseOffset;
    if (u >= ByteUpperA && u <= ByteUpperZ) return int'(u - ByteUpperA);
    return -1;
  endfunction

  // Append a letter to the square unless it is J, already placed, or the square is full
  task automatic append_key(int unsigned idx);
    if (idx == int'(IdxJ) || seen[idx] || fill >= Cells) return;
    square_tab[fill] = IdxW'(idx);
    place_tab[idx]   = PosW'(fill);
    seen[idx]        = 1'b1;
    fill++;
  endtask

  // Queue one plaintext letter taken from a place in the square
  task automatic push_plain(int unsigned row, int unsigned col, bit err);
    int unsigned pos;
    plain_res_t  r;
    pos = row * SquareSide + col;
    if (err || pos >= fill) begin
      r = '{plain_letter: 7'd0, not_in_square: 1'b1, last_of_run: 1'b0};
    end else begin
      r = '{plain_letter: 7'(AsciiUpperA + 7'(square_tab[pos])), not_in_square: 1'b0,
            last_of_run: 1'b0};
    end
    plain_q.push_back(r);
  endtask

  // Decode one digraph into two plaintext letters
  task automatic decode_digraph(int unsigned a, int unsigned b);
    bit          err;
    int unsigned pa, pb, ra, ca, rb, cb;
    err = !seen[a] || !seen[b];
    pa  = err ? 0 : int'(place_tab[a]);
    pb  = err ? 0 : int'(place_tab[b]);
    ra  = pa / SquareSide;
    ca  = pa % SquareSide;
    rb  = pb / SquareSide;
    cb  = pb % SquareSide;
    if (ra == rb) begin
      push_plain(ra, (ca + SquareSide - 1) % SquareSide, err);
      push_plain(rb, (cb + SquareSide - 1) % SquareSide, err);
    end else if (ca == cb) begin
      push_plain((ra + SquareSide - 1) % SquareSide, ca, err);
      push_plain((rb + SquareSide - 1) % SquareSide, cb, err);
    end else begin
      push_plain(ra, cb, err);
      push_plain(rb, ca, err);
    end
  endtask

  // Update the shadow state for one accepted transaction and queue its results
  task automatic predict_plain(cmd_e cmd, logic [7:0] b, logic fin);
    int          c;
    int unsigned n0;
    plain_res_t  tail;
    n0 = plain_q.size();
    case (cmd)
      CMD_CLEAR: begin
        seen        = '0;
        fill        = 0;
        held_valid  = 1'b0;
        held_letter = 0;
      end
      CMD_KEY: begin
        c = letter_index(b);
        if (c >= 0) append_key(c);
      end
      CMD_END_KEY: begin
        for (int i = 0; i < NumLetters; i++) append_key(i);
      end
      default: begin
        c = letter_index(b);
        if (c < 0) begin
          // Non-letter: only flushes a waiting letter at message end
          if (fin && held_valid) begin
            decode_digraph(held_letter, int'(IdxX));
            held_valid = 1'b0;
          end
        end else if (!held_valid) begin
          if (fin) begin
            decode_digraph(c, int'(IdxX));
          end else begin
            held_letter = c;
            held_valid  = 1'b1;
          end
        end else if (held_letter == c) begin
          // Repeated letter: pad with X and keep the new one waiting
          decode_digraph(held_letter, int'(IdxX));
          if (fin) begin
            decode_digraph(c, int'(IdxX));
            held_valid = 1'b0;
          end
        end else begin
          decode_digraph(held_letter, c);
          held_valid = 1'b0;
        end
      end
    endcase
    // Mark the last result of this transaction
    if (plain_q.size() > n0) begin
      tail = plain_q.pop_back();
      tail.last_of_run = 1'b1;
      plain_q.push_back(tail);
    end
  endtask

  // Watch both channels and compare each result with the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    plain_res_t exp_res;
    if (!rst_ni) begin
      seen        = '0;
      fill        = 0;
      held_valid  = 1'b0;
      held_letter = 0;
      plain_q.delete();
      waiting <= 0;
    end else begin
      if (cipher_i.valid && cipher_i.ready) begin
        predict_plain(cmd_e'(cipher_i.command), cipher_i.letter, cipher_i.final_letter);
      end
      if (plain_i.valid && plain_i.ready) begin
        if (plain_q.size() == 0) begin
          $display("%0t: unexpected result: plain_letter %0h not_in_square %0b last_of_run %0b",
                   $time, plain_i.plain_letter, plain_i.not_in_square, plain_i.last_of_run);
          errors++;
        end else begin
          exp_res = plain_q.pop_front();
          if (plain_i.plain_letter !== exp_res.plain_letter) begin
            $display("%0t: plain_letter expected %0h actual %0h",
                     $time, exp_res.plain_letter, plain_i.plain_letter);
            errors++;
          end
          if (plain_i.not_in_square !== exp_res.not_in_square) begin
            $display("%0t: not_in_square expected %0b actual %0b",
                     $time, exp_res.not_in_square, plain_i.not_in_square);
            errors++;
          end
          if (plain_i.last_of_run !== exp_res.last_of_run) begin
            $display("%0t: last_of_run expected %0b actual %0b",
                     $time, exp_res.last_of_run, plain_i.last_of_run);
            errors++;
          end
        end
      end
      waiting <= plain_q.size();
    end
  end

endmodule

>>> tb/tb.sv
// Testbench top for the Playfair decipher engine: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;
  import pfd_pkg::*;

  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned PhaseItems  = 42;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;

  int          mismatches;
  int          outstanding;

  int unsigned send_idle  = 0;
  int unsigned recv_stall = 0;
  int unsigned items_sent = 0;
  bit          hold_kick  = 1'b0;
  bit          hold_seen  = 1'b0;

  pfd_in_if  cipher_if ();
  pfd_out_if plain_if ();

  playfair_decipher i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cipher_i (cipher_if),
    .plain_o  (plain_if)
  );

  pfd_checker i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cipher_i        (cipher_if),
    .plain_i         (plain_if),
    .error_count_o   (mismatches),
    .pending_count_o (outstanding)
  );

  always #5 clk_i = ~clk_i;

  // Bound the run time
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Drive the result ready: random stalls, plus one long hold-off on request
  initial begin
    plain_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_seen != hold_kick) begin
        hold_seen = hold_kick;
        repeat (HoldCycles) begin
          plain_if.ready <= 1'b0;
          @(posedge clk_i);
        end
      end
      plain_if.ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  // Pick a letter byte: mostly A..Z in either case, sometimes any byte
  function automatic logic [7:0] random_letter();
    logic [7:0] u;
    if ($urandom_range(9) == 0) return 8'($urandom_range(255));
    u = ByteUpperA + 8'($urandom_range(25));
    if ($urandom_range(1) == 1) u = u + CaseOffset;
    return u;
  endfunction

  // Offer one transaction after a random gap and hold it until accepted
  task automatic send_item(cmd_e cmd, logic [7:0] b, logic fin);
    while ($urandom_range(99) < send_idle) begin
      cipher_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    cipher_if.valid        <= 1'b1;
    cipher_if.command      <= cmd;
    cipher_if.letter       <= b;
    cipher_if.final_letter <= fin;
    do @(posedge clk_i); while (!cipher_if.ready);
    items_sent++;
  endtask

  // Send a string of key or cipher letters, marking the last one as final if asked
  task automatic send_text(cmd_e cmd, string s, logic fin_last);
    for (int i = 0; i < s.len(); i++) begin
      send_item(cmd, s[i], fin_last && (i == s.len() - 1));
    end
  endtask

  // Send one cipher message of random letters with some repeats
  task automatic send_message(int unsigned len);
    logic [7:0] prev;
    logic [7:0] cur;
    logic       fin;
    prev = random_letter();
    for (int k = 0; k < len; k++) begin
      cur = ($urandom_range(99) < 15) ? prev : random_letter();
      fin = (k == len - 1) ? ($urandom_range(9) != 0) : ($urandom_range(19) == 0);
      if ($urandom_range(19) == 0) begin
        send_item(CMD_KEY, random_letter(), 1'($urandom_range(1)));
      end
      send_item(CMD_CIPHER, cur, fin);
      prev = cur;
    end
  endtask

  // Optionally rebuild the key square, then decode a few messages
  task automatic random_session();
    int unsigned key_len;
    int unsigned msgs;
    if ($urandom_range(3) == 0) begin
      send_item(CMD_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)));
      key_len = $urandom_range(8);
      repeat (key_len) send_item(CMD_KEY, random_letter(), 1'($urandom_range(1)));
      if ($urandom_range(7) != 0) begin
        send_item(CMD_END_KEY, 8'($urandom_range(255)), 1'($urandom_range(1)));
      end
    end
    msgs = $urandom_range(1, 3);
    repeat (msgs) send_message($urandom_range(1, 10));
  endtask

  initial begin
    int unsigned target;
    cipher_if.valid        = 1'b0;
    cipher_if.command      = CMD_CLEAR;
    cipher_if.letter       = 8'h00;
    cipher_if.final_letter = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: decode against an empty square
    send_item(CMD_CLEAR, 8'h00, 1'b0);
    send_text(CMD_CIPHER, "AB", 1'b0);
    // Directed: partial square, one target beyond the filled places
    send_text(CMD_KEY, "Pl", 1'b0);
    send_text(CMD_CIPHER, "LP", 1'b0);
    // Directed: skip J, a non-letter byte and a repeated letter in the key
    send_text(CMD_KEY, "ayJ", 1'b1);
    send_item(CMD_KEY, 8'hFF, 1'b0);
    send_item(CMD_KEY, "a", 1'b0);
    send_item(CMD_END_KEY, 8'h00, 1'b0);
    // Directed: same row, same column
    send_text(CMD_CIPHER, "AY", 1'b0);
    send_text(CMD_CIPHER, "PC", 1'b0);
    // Directed: repeated letter with final gives four results
    send_text(CMD_CIPHER, "EE", 1'b1);
    // Directed: odd trailing letter in lower case
    send_item(CMD_CIPHER, "q", 1'b1);
    // Directed: letter absent from the square
    send_text(CMD_CIPHER, "Ja", 1'b0);
    // Directed: non-letter with final flushes a waiting letter, then with nothing waiting
    send_item(CMD_CIPHER, "K", 1'b0);
    send_item(CMD_CIPHER, "?", 1'b1);
    send_item(CMD_CIPHER, 8'hFF, 1'b1);

    target = items_sent;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin send_idle = 0;  recv_stall = 0;  end
        1:       begin send_idle = 47; recv_stall = 0;  end
        2:       begin send_idle = 0;  recv_stall = 47; end
        default: begin send_idle = 21; recv_stall = 21; end
      endcase
      // Hold off the receiver while a long message fills the block
      if (ph == 0) begin
        hold_kick = ~hold_kick;
        send_message(24);
      end
      target += PhaseItems;
      while (items_sent < target) random_session();
    end
    cipher_if.valid <= 1'b0;

    // Drain remaining results
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      if (outstanding != 0) $display("%0t: %0d results never arrived", $time, outstanding);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
